// ===== hw/rtl/subtractive_random_generator_core_assert.svh =====
// Assertion macros for the subtractive generator core.
// Used inside modules that have clk and arst_n in scope.
`ifndef SUBTRACTIVE_RANDOM_GENERATOR_CORE_ASSERT_SVH
`define SUBTRACTIVE_RANDOM_GENERATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SRG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define SRG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/srg_pkg.sv =====
// Shared types, constants and helpers for the subtractive generator core.
// No dependencies.
package srg_pkg;

	localparam int unsigned TableLen  = 55;
	localparam int unsigned ValueW    = 30;
	localparam int unsigned PosW      = 6;
	localparam int unsigned SeedW     = 32;

	localparam logic [ValueW-1:0] Modulus     = 30'd1000000000;
	localparam logic [SeedW-1:0]  SeedMagic   = 32'd161803398;
	localparam logic [PosW-1:0]   LastPos     = 6'd55;
	localparam logic [PosW-1:0]   ScatterStep = 6'd21;
	localparam logic [PosW-1:0]   TrailStart  = 6'd31;
	localparam logic [PosW-1:0]   OtherStart  = 6'd32;
	localparam logic [PosW-1:0]   ScatterLast = 6'd54;

	localparam logic ModeReseed = 1'b0;
	localparam logic ModeDraw   = 1'b1;

	typedef logic [ValueW-1:0] value_t;
	typedef logic [PosW-1:0]   pos_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIFF,
		ST_MOD,
		ST_TOP,
		ST_SCAT,
		ST_MIX_RD,
		ST_MIX_WR,
		ST_DRAW_RD,
		ST_DRAW_WR
	} state_t;

	// Position step with wrap from 55 (or above) back to 1.
	function automatic pos_t pos_adv(pos_t p);
		pos_t r;
		if (p >= LastPos) begin
			r = pos_t'(1);
		end else begin
			r = p + pos_t'(1);
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/srg_ram.sv =====
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module srg_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr_a,
	output logic [Width-1:0]         rdata_a,
	input  logic [$clog2(Depth)-1:0] raddr_b,
	output logic [Width-1:0]         rdata_b
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// ===== hw/rtl/srg_alu.sv =====
// Shared subtract-modulo unit: y = (a - b) mod 10^9 for a, b below 10^9.
// Depends on srg_pkg.
module srg_alu (
	input  srg_pkg::value_t a,
	input  srg_pkg::value_t b,
	output srg_pkg::value_t y
);
	import srg_pkg::*;

	logic [ValueW:0] diff;
	logic [ValueW:0] wrap;

	assign diff = {1'b0, a} - {1'b0, b};
	assign wrap = diff + {1'b0, Modulus};
	assign y    = diff[ValueW] ? wrap[ValueW-1:0] : diff[ValueW-1:0];

endmodule

// ===== hw/rtl/subtractive_random_generator_core.sv =====
// Subtractive lagged pseudo-random generator, modulo 10^9, 55-entry lag table.
// Depends on srg_pkg, srg_alu, srg_ram and the assertion macro header.
//
// Input channel (in_valid/in_ready): mode and seed. mode 0 reseeds the table
// from seed and returns nothing; mode 1 draws the next value.
// Output channel (out_valid/out_ready): value, one per draw.
// Draw: accepted in idle; DRAW_RD reads both lag entries, then DRAW_WR writes back
// the difference and loads it into the output register once that register is free.
// Reseed: DIFF and MOD fold the seed, TOP and SCAT make 55 writes for the scatter,
// then 4 x 55 mixing steps, each a read (MIX_RD) then a write (MIX_WR) through the
// shared subtract unit on the single-write table RAM.
// The result sits in an output register; a new item is taken while it waits.
// A draw that finishes while the previous value is still unread holds until
// the receiver takes it.
// Reset: indices zero and the table reads as all zeros (a seeded flag masks
// the RAM until the first reseed fills every entry), so draws return zero.
module subtractive_random_generator_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          mode,
	input  logic signed [srg_pkg::SeedW-1:0] seed,
	output logic                          out_valid,
	input  logic                          out_ready,
	output srg_pkg::value_t               value
);
	import srg_pkg::*;

	state_t state_q, state_d;

	pos_t   lead_q, trail_q;
	pos_t   pos_q, cnt_q, other_q;
	logic [1:0] pass_q;
	logic   seeded_q;
	logic   out_valid_q;
	value_t value_q;
	value_t prev_q, cur_q;
	logic [SeedW-1:0]  mag_q;
	logic [SeedW-2:0]  diff_q;

	logic   mem_we;
	pos_t   mem_waddr, raddr_a, raddr_b;
	value_t mem_wdata, rdata_a, rdata_b;
	value_t alu_a, alu_b, alu_y;
	logic   out_free;
	logic   in_xfer;
	logic [SeedW-1:0] seed_u;
	logic [SeedW-1:0] mag_d;
	logic [6:0] pos_sum;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign out_free  = !out_valid_q || out_ready;

	assign seed_u  = seed;
	assign mag_d   = (seed_u == '0) ? SeedW'(1) :
	                 (seed_u[SeedW-1] ? (~seed_u + SeedW'(1)) : seed_u);
	assign pos_sum = {1'b0, pos_q} + {1'b0, ScatterStep};

	srg_ram #(
		.Width(ValueW),
		.Depth(TableLen)
	) u_table (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.raddr_a(raddr_a),
		.rdata_a(rdata_a),
		.raddr_b(raddr_b),
		.rdata_b(rdata_b)
	);

	srg_alu u_alu (
		.a(alu_a),
		.b(alu_b),
		.y(alu_y)
	);

	// ALU operands: prev_q and cur_q in scatter, else table data (zero while unseeded).
	always_comb begin
		if (state_q == ST_SCAT) begin
			alu_a = prev_q;
			alu_b = cur_q;
		end else begin
			alu_a = seeded_q ? rdata_a : '0;
			alu_b = seeded_q ? rdata_b : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = alu_y;
		raddr_a   = lead_q - pos_t'(1);
		raddr_b   = trail_q - pos_t'(1);
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					state_d = (mode == ModeDraw) ? ST_DRAW_RD : ST_DIFF;
				end
			end
			ST_DIFF: state_d = ST_MOD;
			ST_MOD:  state_d = ST_TOP;
			ST_TOP: begin
				mem_we    = 1'b1;
				mem_waddr = LastPos - pos_t'(1);
				mem_wdata = prev_q;
				state_d   = ST_SCAT;
			end
			ST_SCAT: begin
				mem_we    = 1'b1;
				mem_waddr = pos_q - pos_t'(1);
				mem_wdata = cur_q;
				if (cnt_q == ScatterLast) begin
					state_d = ST_MIX_RD;
				end
			end
			ST_MIX_RD: begin
				raddr_a = cnt_q - pos_t'(1);
				raddr_b = other_q - pos_t'(1);
				state_d = ST_MIX_WR;
			end
			ST_MIX_WR: begin
				mem_we    = 1'b1;
				mem_waddr = cnt_q - pos_t'(1);
				if (cnt_q == LastPos && pass_q == 2'd3) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_MIX_RD;
				end
			end
			ST_DRAW_RD: state_d = ST_DRAW_WR;
			ST_DRAW_WR: begin
				if (out_free) begin
					mem_we    = 1'b1;
					mem_waddr = lead_q - pos_t'(1);
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q      <= '0;
			trail_q     <= '0;
			cnt_q       <= '0;
			other_q     <= '0;
			pass_q      <= '0;
			pos_q       <= '0;
			seeded_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DRAW_WR && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer && mode == ModeDraw) begin
						lead_q  <= pos_adv(lead_q);
						trail_q <= pos_adv(trail_q);
					end
				end
				ST_TOP: begin
					seeded_q <= 1'b1;
					cnt_q    <= pos_t'(1);
					pos_q    <= ScatterStep;
				end
				ST_SCAT: begin
					pos_q <= (pos_sum >= 7'(TableLen)) ? pos_t'(pos_sum - 7'(TableLen))
					                                   : pos_sum[PosW-1:0];
					if (cnt_q == ScatterLast) begin
						cnt_q   <= pos_t'(1);
						other_q <= OtherStart;
						pass_q  <= '0;
					end else begin
						cnt_q <= cnt_q + pos_t'(1);
					end
				end
				ST_MIX_WR: begin
					if (cnt_q == LastPos) begin
						cnt_q   <= pos_t'(1);
						other_q <= OtherStart;
						pass_q  <= pass_q + 2'd1;
						if (pass_q == 2'd3) begin
							lead_q  <= '0;
							trail_q <= TrailStart;
						end
					end else begin
						cnt_q   <= cnt_q + pos_t'(1);
						other_q <= pos_adv(other_q);
					end
				end
				default: ;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					mag_q <= mag_d;
				end
			end
			ST_DIFF: begin
				diff_q <= (mag_q > SeedMagic) ? (SeedW-1)'(mag_q - SeedMagic)
				                              : (SeedW-1)'(SeedMagic - mag_q);
			end
			ST_MOD: begin
				prev_q <= (diff_q >= (SeedW-1)'(Modulus))
					? ValueW'(diff_q - (SeedW-1)'(Modulus)) : ValueW'(diff_q);
			end
			ST_TOP: cur_q <= value_t'(1);
			ST_SCAT: begin
				cur_q  <= alu_y;
				prev_q <= cur_q;
			end
			ST_DRAW_WR: begin
				if (out_free) begin
					value_q <= alu_y;
				end
			end
			default: ;
		endcase
	end

`include "subtractive_random_generator_core_assert.svh"

	`SRG_ASSERT_NOW(a_value_range, out_valid_q, value_q < Modulus, "value out of range")
	`SRG_ASSERT_NOW(a_idx_range, 1'b1, lead_q <= LastPos && trail_q <= LastPos, "index over 55")
	`SRG_ASSERT_NOW(a_no_idle_write, state_q == ST_IDLE, !mem_we, "table write while idle")
	`SRG_ASSERT_NEXT(a_reseed_done, state_q == ST_MIX_WR && state_d == ST_IDLE,
		lead_q == '0 && trail_q == TrailStart && seeded_q, "reseed left bad indices")

endmodule
